[hdl/abp_pkg.sv]
`timescale 1ns / 1ps

package abp_pkg;

    localparam int PIXEL_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int CFG_INDEX_W = 2;

    // Fully opaque alpha or full glyph coverage
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_COLOR = 2'd1;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_RGBA  = 2'd1,
        MODE_GLYPH = 2'd2
    } t_blend_mode;

endpackage

[hdl/abp_chan_mix.sv]
`timescale 1ns / 1ps

// One colour channel: d + floor((s - d) * a / 256), kept to eight bits
module abp_chan_mix
    import abp_pkg::*;
(
    input  logic [CHAN_W-1:0] i_src,
    input  logic [CHAN_W-1:0] i_dst,
    input  logic [CHAN_W-1:0] i_alpha,
    output logic [CHAN_W-1:0] o_mix
);

    logic signed [CHAN_W:0]       diff;
    logic signed [2*CHAN_W+1:0]   prod;
    logic signed [2*CHAN_W+1:0]   step;

    // Signed difference times unsigned alpha, floored by arithmetic shift
    assign diff = $signed({1'b0, i_src}) - $signed({1'b0, i_dst});
    assign prod = diff * $signed({1'b0, i_alpha});
    assign step = prod >>> CHAN_W;

    // Wraps modulo 256; the true result always lies in range
    assign o_mix = step[CHAN_W-1:0] + i_dst;

endmodule

[hdl/abp_blend.sv]
`timescale 1ns / 1ps

// Mode selection and three-channel blend for one pixel
module abp_blend
    import abp_pkg::*;
(
    input  t_blend_mode          i_mode,
    input  logic [PIXEL_W-1:0]   i_glyph_color,
    input  logic [PIXEL_W-1:0]   i_source_pixel,
    input  logic [PIXEL_W-1:0]   i_dest_pixel,
    output logic [PIXEL_W-1:0]   o_result_pixel
);

    logic [CHAN_W-1:0]  alpha;
    logic [PIXEL_W-1:0] colour_src;
    logic [3*CHAN_W-1:0] rgb_mix;

    // Pick the blend alpha and colour source for the mode
    always_comb begin
        if (i_mode == MODE_GLYPH) begin
            alpha      = i_source_pixel[CHAN_W-1:0];
            colour_src = i_glyph_color;
        end else begin
            alpha      = i_source_pixel[PIXEL_W-1 -: CHAN_W];
            colour_src = i_source_pixel;
        end
    end

    // Blend B, G and R in parallel
    for (genvar k = 0; k < 3; k++) begin : g_chan
        abp_chan_mix u_mix (
            .i_src   (colour_src[k*CHAN_W +: CHAN_W]),
            .i_dst   (i_dest_pixel[k*CHAN_W +: CHAN_W]),
            .i_alpha (alpha),
            .o_mix   (rgb_mix[k*CHAN_W +: CHAN_W])
        );
    end

    // Assemble the result word
    always_comb begin
        unique case (i_mode)
            MODE_COPY: begin
                o_result_pixel = i_source_pixel;
            end
            MODE_RGBA: begin
                if (alpha == ALPHA_OPAQUE) begin
                    o_result_pixel = i_source_pixel;
                end else begin
                    o_result_pixel = {i_dest_pixel[PIXEL_W-1 -: CHAN_W], rgb_mix};
                end
            end
            MODE_GLYPH: begin
                if (alpha == ALPHA_OPAQUE) begin
                    o_result_pixel = i_glyph_color;
                end else begin
                    o_result_pixel = {ALPHA_OPAQUE, rgb_mix};
                end
            end
            default: begin
                // Unused selector: destination passes unchanged
                o_result_pixel = i_dest_pixel;
            end
        endcase
    end

endmodule

[hdl/alpha_blend_pixel_unit.sv]
`timescale 1ns / 1ps
// The pixel passes the input register and then the result register before its result
// is offered; a stall on the result side holds it in the result register.
// Throughput: one pixel per cycle unless the result side stalls; the blend is a single
// multiply-add per channel between the two registers.
// Reset (synchronous, active low): both pipeline stages empty, blend mode copy,
// glyph colour zero.
module alpha_blend_pixel_unit
    import abp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [PIXEL_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PIXEL_W-1:0]     i_source_pixel,
    input  logic [PIXEL_W-1:0]     i_dest_pixel,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [PIXEL_W-1:0]     o_result_pixel
);

    t_blend_mode        r_mode;
    logic [PIXEL_W-1:0] r_glyph_color;

    logic               r_in_valid;
    logic [PIXEL_W-1:0] r_source_pixel;
    logic [PIXEL_W-1:0] r_dest_pixel;
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_result_pixel;
    logic [PIXEL_W-1:0] n_result_pixel;

    logic out_take;
    logic in_take;

    // Stage handshakes: each stage refills when empty or when it drains
    assign out_take   = !r_out_valid || !i_out_stall;
    assign in_take    = !r_in_valid || out_take;
    assign o_in_stall = !in_take;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_COPY;
            r_glyph_color <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BLEND_MODE) begin
                r_mode <= t_blend_mode'(i_cfg_data[1:0]);
            end else if (i_cfg_index == CFG_GLYPH_COLOR) begin
                r_glyph_color <= i_cfg_data;
            end
        end
    end

    // Input register: capture on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_source_pixel <= i_source_pixel;
            r_dest_pixel   <= i_dest_pixel;
        end
    end

    abp_blend u_blend (
        .i_mode         (r_mode),
        .i_glyph_color  (r_glyph_color),
        .i_source_pixel (r_source_pixel),
        .i_dest_pixel   (r_dest_pixel),
        .o_result_pixel (n_result_pixel)
    );

    // Result register: hold while stalled, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_in_valid) begin
            r_result_pixel <= n_result_pixel;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_pixel = r_result_pixel;

endmodule
